### hdl/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg: shared constants, trig ROMs and control types
// Holds the map and screen geometry, the Q16.16 degree tables, the
// controller state type and the command and status words that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package rcr_pkg;

    // Geometry of the map, the fan of rays and the screen.
    localparam int MAP_SIDE    = 16;
    localparam int RAY_COUNT   = 60;
    localparam int SCREEN_ROWS = 160;
    localparam int HALF_RAYS   = RAY_COUNT / 2;
    localparam int CENTER_ROW  = SCREEN_ROWS / 2;

    // Datapath widths.
    localparam int CELL_W   = 4;
    localparam int TRIG_W   = 23;
    localparam int POS_W    = 40;
    localparam int DD_W     = 12;
    localparam int DIST_W   = 32;
    localparam int MUL_A_W  = 32;
    localparam int PROD_W   = MUL_A_W + TRIG_W;
    localparam int DIV_BITS = 30;
    localparam int CNT_W    = 5;

    // Slice height constant: 64 * round(207.85 * 2^16).
    localparam logic [DIV_BITS-1:0] SLICE_K = 30'd871786112;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS_0_TO_3   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS_4_TO_7   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS_8_TO_11  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS_12_TO_15 = 8'd3;
    localparam int CFG_REG_COUNT = 4;

    typedef logic [0:90][TRIG_W-1:0] t_trig_rom;

    // Unsigned long division by shift and subtract, used only while the
    // tables are built; both operands are nonnegative.
    function automatic longint udiv64(input longint num, input longint den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= 64'(den)) begin
                rem    = rem - 64'(den);
                quo[b] = 1'b1;
            end
        end
        return longint'(quo);
    endfunction

    // Sine of r degrees in Q16.16 from a nine-term series in Q28.
    function automatic longint sin_entry(input int r);
        longint x;
        longint term;
        longint sum;
        x    = udiv64(longint'(r) * 64'sd843314857 + 64'sd90, 64'sd180);
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >>> 28;
            term = (term * x) >>> 28;
            term = udiv64(term, longint'((2 * n) * (2 * n + 1)));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd2048) >>> 12;
        if (sum > 64'sd65536) begin
            sum = 64'sd65536;
        end
        return sum;
    endfunction

    function automatic t_trig_rom build_sin();
        t_trig_rom rom;
        for (int r = 0; r <= 90; r++) begin
            rom[r] = TRIG_W'(sin_entry(r));
        end
        return rom;
    endfunction

    function automatic t_trig_rom build_tan();
        t_trig_rom rom;
        longint    sn;
        longint    cs;
        for (int r = 0; r <= 90; r++) begin
            sn = sin_entry(r);
            cs = sin_entry(90 - r);
            rom[r] = (r < 90 && cs > 0) ? TRIG_W'(udiv64(sn * 65536 + cs / 2, cs)) : '0;
        end
        return rom;
    endfunction

    function automatic t_trig_rom build_cot();
        t_trig_rom rom;
        longint    sn;
        longint    cs;
        for (int r = 0; r <= 90; r++) begin
            sn = sin_entry(r);
            cs = sin_entry(90 - r);
            rom[r] = (r > 0 && sn > 0) ? TRIG_W'(udiv64(cs * 65536 + sn / 2, sn)) : '0;
        end
        return rom;
    endfunction

    function automatic t_trig_rom build_csc();
        t_trig_rom rom;
        longint    sn;
        for (int r = 0; r <= 90; r++) begin
            sn = sin_entry(r);
            rom[r] = (r > 0 && sn > 0) ? TRIG_W'(udiv64((64'sd1 <<< 32) + sn / 2, sn)) : '0;
        end
        return rom;
    endfunction

    localparam t_trig_rom SIN_ROM = build_sin();
    localparam t_trig_rom TAN_ROM = build_tan();
    localparam t_trig_rom COT_ROM = build_cot();
    localparam t_trig_rom CSC_ROM = build_csc();

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_RAY,
        OP_WALK_INIT,
        OP_WALK_POS,
        OP_WALK_STEP,
        OP_HIT_MUL,
        OP_HIT_SAT,
        OP_PICK,
        OP_COS_MUL,
        OP_COS_SAT,
        OP_DIV_STEP,
        OP_SLICE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   vert;
    } t_dp_cmd;

    typedef struct packed {
        logic h_skip;
        logic v_skip;
        logic walk_exit;
        logic walk_hit;
        logic any_hit;
        logic dist_zero;
        logic div_done;
        logic last_ray;
        logic out_free;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RAY,
        S_H_INIT,
        S_H_POS,
        S_H_WALK,
        S_H_MUL,
        S_H_SAT,
        S_V_INIT,
        S_V_POS,
        S_V_WALK,
        S_V_MUL,
        S_V_SAT,
        S_PICK,
        S_COS_MUL,
        S_COS_SAT,
        S_DIV,
        S_EMIT
    } t_ctrl_state;

endpackage

### hdl/grid_raycast_column_renderer.sv
// ----------------------------------------------------------------------------
// grid_raycast_column_renderer: wall slices for one frame of a grid ray caster
// Takes a viewer position and heading and returns one wall slice word per
// ray, in ray order, for a fan of rays one degree apart.
// ----------------------------------------------------------------------------
// One input word yields RAY_COUNT output words. Each ray passes through setup,
// selection, fisheye correction and output, one cycle per grid crossing in each
// of its two walks (at most 15 crossings each on a 16 by 16 map), and through
// the bit-serial slice divider when it hits a wall; a stalled output holds a
// ray until its word can be issued. The input is stalled for the whole frame.
// Write the map registers only while the block is idle; the block itself does
// not enforce this.
module grid_raycast_column_renderer import rcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [9:0]           i_viewer_x,
    input  logic [9:0]           i_viewer_y,
    input  logic [8:0]           i_heading_deg,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [5:0]           o_column_index,
    output logic [7:0]           o_wall_top,
    output logic [7:0]           o_wall_bottom,
    output logic                 o_dark_side,
    output logic                 o_last_column
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [CELL_W-1:0] map_row;
    logic [CELL_W-1:0] map_col;
    logic              wall;

    // Sequencer.
    rcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Wall bitmap.
    rcr_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_row       (map_row),
        .i_col       (map_col),
        .o_wall      (wall)
    );

    // Datapath.
    rcr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_viewer_x     (i_viewer_x),
        .i_viewer_y     (i_viewer_y),
        .i_heading_deg  (i_heading_deg),
        .i_wall         (wall),
        .o_map_row      (map_row),
        .o_map_col      (map_col),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_column_index (o_column_index),
        .o_wall_top     (o_wall_top),
        .o_wall_bottom  (o_wall_bottom),
        .o_dark_side    (o_dark_side),
        .o_last_column  (o_last_column)
    );

endmodule

### hdl/rcr_map.sv
// ----------------------------------------------------------------------------
// rcr_map: wall bitmap registers
// Four 64-bit configuration registers hold sixteen rows of sixteen wall bits;
// the datapath looks up one cell at a time.
// ----------------------------------------------------------------------------
module rcr_map import rcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [CELL_W-1:0]    i_row,
    input  logic [CELL_W-1:0]    i_col,
    output logic                 o_wall
);

    logic [63:0] r_map [0:CFG_REG_COUNT-1];

    // Register writes; indexes beyond the map registers are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REG_COUNT; i++) begin
                r_map[i] <= '0;
            end
        end else if (i_cfg_we && i_cfg_index <= CFG_MAP_ROWS_12_TO_15) begin
            r_map[i_cfg_index[1:0]] <= i_cfg_data;
        end
    end

    // Row r sits in register r/4 at bit (r%4)*16 + column.
    assign o_wall = r_map[i_row[3:2]][{i_row[1:0], i_col}];

endmodule

### hdl/rcr_dp.sv
// ----------------------------------------------------------------------------
// rcr_dp: ray casting datapath
// Viewer registers, the shared grid walker, one shared multiplier, a
// restoring divider for the slice height and the output word register.
// ----------------------------------------------------------------------------
module rcr_dp import rcr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [9:0]        i_viewer_x,
    input  logic [9:0]        i_viewer_y,
    input  logic [8:0]        i_heading_deg,
    input  logic              i_wall,
    output logic [CELL_W-1:0] o_map_row,
    output logic [CELL_W-1:0] o_map_col,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [5:0]        o_column_index,
    output logic [7:0]        o_wall_top,
    output logic [7:0]        o_wall_bottom,
    output logic              o_dark_side,
    output logic              o_last_column
);

    logic [9:0]                r_px;
    logic [9:0]                r_py;
    logic [8:0]                r_head;
    logic [5:0]                r_ray;
    logic [8:0]                r_ang;
    logic [6:0]                r_ref;
    logic [6:0]                r_off;
    logic                      r_up;
    logic                      r_right;
    logic                      r_vert;
    logic [DD_W-1:0]           r_dd;
    logic signed [5:0]         r_cell;
    logic signed [POS_W-1:0]   r_pos;
    logic signed [POS_W-1:0]   r_step;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_hit_h;
    logic                      r_hit_v;
    logic [DIST_W-1:0]         r_dist_h;
    logic [DIST_W-1:0]         r_dist_v;
    logic [DIST_W-1:0]         r_d;
    logic                      r_dark;
    logic [DIST_W-1:0]         r_rem;
    logic [DIV_BITS-1:0]       r_quo;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_ovalid;
    logic [5:0]                r_o_col;
    logic [7:0]                r_o_top;
    logic [7:0]                r_o_bot;
    logic                      r_o_dark;
    logic                      r_o_last;

    logic signed [10:0]        ang_raw;
    logic [10:0]               ang_fix;
    logic [8:0]                ang;
    logic [8:0]                ref_wide;
    logic signed [6:0]         off_raw;
    logic [6:0]                off_abs;
    logic [6:0]                ref_cmp;
    logic [9:0]                coord;
    logic                      toward_low;
    logic [DD_W-1:0]           dd0;
    logic signed [5:0]         cell0;
    logic [TRIG_W-1:0]         init_trig;
    logic                      step_neg;
    logic signed [POS_W-1:0]   step_mag;
    logic signed [POS_W-1:0]   base;
    logic signed [POS_W-1:0]   off_prod;
    logic                      cell_dec;
    logic [POS_W-23:0]         pos_cell;
    logic                      walk_exit;
    logic [MUL_A_W-1:0]        mul_a;
    logic [TRIG_W-1:0]         mul_b;
    logic [PROD_W-17:0]        cos_shift;
    logic [DIST_W:0]           div_part;
    logic                      div_ge;
    logic [DIST_W:0]           div_diff;
    logic                      full;
    logic [7:0]                top_n;
    logic [8:0]                len9;
    logic [8:0]                room;
    logic [8:0]                bot_sum;
    logic [7:0]                bot_n;

    // Ray angle, reference angle and offset from the heading.
    assign ang_raw  = 11'({2'b00, r_head}) + 11'(HALF_RAYS) - 11'({5'b0, r_ray});
    assign ang_fix  = ang_raw[10] ? 11'(ang_raw + 11'sd360)
                    : (ang_raw >= 11'sd360) ? 11'(ang_raw - 11'sd360) : 11'(ang_raw);
    assign ang      = ang_fix[8:0];
    always_comb begin
        priority if (ang <= 9'd90) begin
            ref_wide = ang;
        end else if (ang <= 9'd180) begin
            ref_wide = 9'd180 - ang;
        end else if (ang <= 9'd270) begin
            ref_wide = ang - 9'd180;
        end else begin
            ref_wide = 9'd360 - ang;
        end
    end
    assign off_raw  = 7'(HALF_RAYS) - {1'b0, r_ray};
    assign off_abs  = off_raw[6] ? 7'(-off_raw) : 7'(off_raw);
    assign ref_cmp  = 7'd90 - r_ref;

    // Walk setup: the horizontal walk runs along y, the vertical one along x.
    assign coord      = i_cmd.vert ? r_px : r_py;
    assign toward_low = i_cmd.vert ? !r_right : r_up;
    assign dd0        = toward_low ? DD_W'(coord[5:0]) : DD_W'(7'd64 - {1'b0, coord[5:0]});
    assign cell0      = toward_low ? $signed({2'b00, coord[9:6]}) - 6'sd1
                                   : $signed({2'b00, coord[9:6]}) + 6'sd1;
    assign init_trig  = i_cmd.vert ? TAN_ROM[r_ref] : COT_ROM[r_ref];
    assign step_neg   = i_cmd.vert ? r_up : !r_right;
    assign step_mag   = $signed({11'b0, init_trig, 6'b0});
    assign base       = $signed({14'b0, (r_vert ? r_py : r_px), 16'b0});
    assign off_prod   = $signed(r_prod[POS_W-1:0]);
    assign cell_dec   = r_vert ? !r_right : r_up;

    // Current crossing: out of the map or on a wall cell.
    assign pos_cell  = r_pos[POS_W-1:22];
    assign walk_exit = r_pos[POS_W-1] || r_cell[5] || (r_cell >= 6'sd16)
                     || (r_cell >= $signed(6'(MAP_SIDE))) || (pos_cell >= 18'(MAP_SIDE));
    assign o_map_row = r_vert ? r_pos[22 +: CELL_W] : r_cell[CELL_W-1:0];
    assign o_map_col = r_vert ? r_cell[CELL_W-1:0] : r_pos[22 +: CELL_W];

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_WALK_INIT: begin
                mul_a = MUL_A_W'(dd0);
                mul_b = init_trig;
            end
            OP_HIT_MUL: begin
                mul_a = MUL_A_W'(r_dd);
                mul_b = r_vert ? CSC_ROM[ref_cmp] : CSC_ROM[r_ref];
            end
            OP_COS_MUL: begin
                mul_a = r_d;
                mul_b = SIN_ROM[7'd90 - r_off];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider step and fisheye shift.
    assign cos_shift = r_prod[PROD_W-1:16];
    assign div_part  = {r_rem, SLICE_K[r_cnt - CNT_W'(1)]};
    assign div_ge    = div_part >= {1'b0, r_d};
    assign div_diff  = div_part - {1'b0, r_d};

    // Slice limits from the slice length.
    assign full    = (r_d == '0) || (r_quo[DIV_BITS-1:1] > 29'(CENTER_ROW));
    assign top_n   = 8'(CENTER_ROW) - r_quo[8:1];
    assign len9    = r_quo[8:0];
    assign room    = 9'(SCREEN_ROWS) - {1'b0, top_n};
    assign bot_sum = {1'b0, top_n} + len9;
    assign bot_n   = (len9 > room) ? 8'(SCREEN_ROWS) : bot_sum[7:0];

    // Working registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_px   <= i_viewer_x;
                r_py   <= i_viewer_y;
                r_head <= (i_heading_deg >= 9'd360) ? i_heading_deg - 9'd360 : i_heading_deg;
                r_ray  <= '0;
            end
            OP_RAY: begin
                r_ang   <= ang;
                r_ref   <= ref_wide[6:0];
                r_off   <= off_abs;
                r_up    <= ang < 9'd180;
                r_right <= (ang < 9'd90) || (ang > 9'd270);
                r_hit_h <= 1'b0;
                r_hit_v <= 1'b0;
            end
            OP_WALK_INIT: begin
                r_vert <= i_cmd.vert;
                r_dd   <= dd0;
                r_cell <= cell0;
                r_step <= step_neg ? -step_mag : step_mag;
                r_prod <= mul_a * mul_b;
            end
            OP_WALK_POS: begin
                r_pos <= (r_vert ? r_up : !r_right) ? base - off_prod : base + off_prod;
            end
            OP_WALK_STEP: begin
                r_pos  <= r_pos + r_step;
                r_dd   <= r_dd + DD_W'(64);
                r_cell <= cell_dec ? r_cell - 6'sd1 : r_cell + 6'sd1;
            end
            OP_HIT_MUL: begin
                r_prod <= mul_a * mul_b;
            end
            OP_HIT_SAT: begin
                if (r_vert) begin
                    r_hit_v  <= 1'b1;
                    r_dist_v <= (|r_prod[PROD_W-1:DIST_W]) ? '1 : r_prod[DIST_W-1:0];
                end else begin
                    r_hit_h  <= 1'b1;
                    r_dist_h <= (|r_prod[PROD_W-1:DIST_W]) ? '1 : r_prod[DIST_W-1:0];
                end
            end
            OP_PICK: begin
                // Equal distances go to the horizontal hit.
                if (r_hit_v && (!r_hit_h || r_dist_v < r_dist_h)) begin
                    r_d    <= r_dist_v;
                    r_dark <= 1'b1;
                end else begin
                    r_d    <= r_dist_h;
                    r_dark <= 1'b0;
                end
            end
            OP_COS_MUL: begin
                r_prod <= mul_a * mul_b;
            end
            OP_COS_SAT: begin
                r_d   <= (|cos_shift[PROD_W-17:DIST_W]) ? '1 : cos_shift[DIST_W-1:0];
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CNT_W'(DIV_BITS);
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? div_diff[DIST_W-1:0] : div_part[DIST_W-1:0];
                r_quo <= {r_quo[DIV_BITS-2:0], div_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            OP_SLICE: begin
                r_ray <= r_ray + 6'd1;
            end
            default: begin
            end
        endcase
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_SLICE) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_SLICE) begin
            r_o_col  <= r_ray;
            r_o_last <= r_ray == 6'(RAY_COUNT - 1);
            if (!(r_hit_h || r_hit_v)) begin
                r_o_top  <= 8'(CENTER_ROW);
                r_o_bot  <= 8'(CENTER_ROW);
                r_o_dark <= 1'b0;
            end else begin
                r_o_top  <= full ? 8'd0 : top_n;
                r_o_bot  <= full ? 8'(SCREEN_ROWS) : bot_n;
                r_o_dark <= r_dark;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_column_index = r_o_col;
    assign o_wall_top     = r_o_top;
    assign o_wall_bottom  = r_o_bot;
    assign o_dark_side    = r_o_dark;
    assign o_last_column  = r_o_last;

    // Status back to the controller.
    always_comb begin
        o_stat.h_skip    = (r_ang == 9'd0) || (r_ang == 9'd180);
        o_stat.v_skip    = (r_ang == 9'd90) || (r_ang == 9'd270);
        o_stat.walk_exit = walk_exit;
        o_stat.walk_hit  = !walk_exit && i_wall;
        o_stat.any_hit   = r_hit_h || r_hit_v;
        o_stat.dist_zero = r_d == '0;
        o_stat.div_done  = r_cnt == '0;
        o_stat.last_ray  = r_ray == 6'(RAY_COUNT - 1);
        o_stat.out_free  = !r_ovalid || !i_stall;
    end

    // A new word never overwrites one that is still waiting.
    a_slice_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SLICE) |-> (!r_ovalid || !i_stall))
        else $error("output word overwritten while stalled");

    // Slice limits stay ordered and on the screen.
    a_slice_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_wall_top <= o_wall_bottom && o_wall_bottom <= 8'(SCREEN_ROWS)))
        else $error("wall slice limits out of order");

    // The divider only steps with bits left and a nonzero divisor.
    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV_STEP) |-> (r_cnt != '0 && r_d != '0))
        else $error("divider stepped past its last bit");

endmodule

### hdl/rcr_ctrl.sv
// ----------------------------------------------------------------------------
// rcr_ctrl: ray casting sequencer
// Steps each ray through setup, the horizontal and vertical grid walks,
// distance selection, fisheye correction, division and output.
// ----------------------------------------------------------------------------
module rcr_ctrl import rcr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_IDLE;
        o_cmd.vert = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_RAY;
                end
            end
            S_RAY: begin
                o_cmd.op = OP_RAY;
                n_state  = S_H_INIT;
            end
            S_H_INIT: begin
                if (i_stat.h_skip) begin
                    n_state = S_V_INIT;
                end else begin
                    o_cmd.op = OP_WALK_INIT;
                    n_state  = S_H_POS;
                end
            end
            S_H_POS: begin
                o_cmd.op = OP_WALK_POS;
                n_state  = S_H_WALK;
            end
            S_H_WALK: begin
                priority if (i_stat.walk_exit) begin
                    n_state = S_V_INIT;
                end else if (i_stat.walk_hit) begin
                    n_state = S_H_MUL;
                end else begin
                    o_cmd.op = OP_WALK_STEP;
                end
            end
            S_H_MUL: begin
                o_cmd.op = OP_HIT_MUL;
                n_state  = S_H_SAT;
            end
            S_H_SAT: begin
                o_cmd.op = OP_HIT_SAT;
                n_state  = S_V_INIT;
            end
            S_V_INIT: begin
                if (i_stat.v_skip) begin
                    n_state = S_PICK;
                end else begin
                    o_cmd.op   = OP_WALK_INIT;
                    o_cmd.vert = 1'b1;
                    n_state    = S_V_POS;
                end
            end
            S_V_POS: begin
                o_cmd.op = OP_WALK_POS;
                n_state  = S_V_WALK;
            end
            S_V_WALK: begin
                priority if (i_stat.walk_exit) begin
                    n_state = S_PICK;
                end else if (i_stat.walk_hit) begin
                    n_state = S_V_MUL;
                end else begin
                    o_cmd.op = OP_WALK_STEP;
                end
            end
            S_V_MUL: begin
                o_cmd.op = OP_HIT_MUL;
                n_state  = S_V_SAT;
            end
            S_V_SAT: begin
                o_cmd.op = OP_HIT_SAT;
                n_state  = S_PICK;
            end
            S_PICK: begin
                o_cmd.op = OP_PICK;
                n_state  = S_COS_MUL;
            end
            S_COS_MUL: begin
                if (!i_stat.any_hit) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = OP_COS_MUL;
                    n_state  = S_COS_SAT;
                end
            end
            S_COS_SAT: begin
                o_cmd.op = OP_COS_SAT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_stat.dist_zero || i_stat.div_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_SLICE;
                    n_state  = i_stat.last_ray ? S_IDLE : S_RAY;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = r_state != S_IDLE;

endmodule

### verif/grid_raycast_column_renderer_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_raycast_column_renderer_check: slice predictor and output checker
// Watches the map register port and both word channels, predicts the wall
// slice of every ray of each accepted frame and compares every output word,
// field by field, with the oldest predicted slice.
// ----------------------------------------------------------------------------
module grid_raycast_column_renderer_check import rcr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    input  logic                 i_in_stall,
    input  logic [9:0]           i_viewer_x,
    input  logic [9:0]           i_viewer_y,
    input  logic [8:0]           i_heading_deg,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [5:0]           i_column_index,
    input  logic [7:0]           i_wall_top,
    input  logic [7:0]           i_wall_bottom,
    input  logic                 i_dark_side,
    input  logic                 i_last_column,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [5:0] column;
        logic [7:0] top;
        logic [7:0] bottom;
        logic       dark;
        logic       last;
    } t_slice;

    localparam longint unsigned DIST_SAT = 64'hFFFF_FFFF;

    longint sine_q16 [0:90];
    longint tan_q16  [0:90];
    longint cot_q16  [0:90];
    longint csc_q16  [0:90];
    logic [63:0] map_bits [0:3];
    t_slice      slice_queue [$];

    // Degree tables: series sine in Q28, rounded into Q16.16.
    initial begin
        longint x, term, sum, sn, cs;
        for (int r = 0; r <= 90; r++) begin
            x = (longint'(r) * 64'sd843314857 + 64'sd90) / 64'sd180;
            term = x;
            sum = x;
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >>> 28;
                term = (term * x) >>> 28;
                term = term / longint'((2 * n) * (2 * n + 1));
                sum = (n % 2 == 1) ? sum - term : sum + term;
            end
            if (sum < 0) sum = 0;
            sum = (sum + 2048) >>> 12;
            if (sum > 65536) sum = 65536;
            sine_q16[r] = sum;
        end
        for (int r = 0; r <= 90; r++) begin
            sn = sine_q16[r];
            cs = sine_q16[90 - r];
            tan_q16[r] = (r < 90 && cs > 0) ? (sn * 65536 + cs / 2) / cs : 0;
            cot_q16[r] = (r > 0 && sn > 0) ? (cs * 65536 + sn / 2) / sn : 0;
            csc_q16[r] = (r > 0 && sn > 0) ? ((64'sd1 <<< 32) + sn / 2) / sn : 0;
        end
    end

    function automatic bit is_wall(longint row, longint col);
        return map_bits[(row >> 2) & 3][((row & 3) * 16 + (col & 15)) & 63];
    endfunction

    // Walks one family of grid lines; horiz selects horizontal lines.
    function automatic bit walk_lines(bit horiz, longint px, longint py, int ang, int ref_deg,
                                      output longint unsigned hit_dist);
        bit     up, right, dec, fwd;
        longint base, along, line, dd, line_idx, off, step, pos, other, slope, prod;
        up = ang < 180;
        right = (ang < 90) || (ang > 270);
        dec = horiz ? up : !right;
        fwd = horiz ? right : !up;
        base = horiz ? py : px;
        along = horiz ? px : py;
        slope = horiz ? cot_q16[ref_deg] : tan_q16[ref_deg];
        hit_dist = 0;
        if (dec) begin
            line = (base / 64) * 64;
            dd = base - line;
            line_idx = line / 64 - 1;
        end else begin
            line = (base / 64) * 64 + 64;
            dd = line - base;
            line_idx = line / 64;
        end
        off = dd * slope;
        step = 64 * slope;
        pos = along * 65536 + (fwd ? off : -off);
        for (int n = 0; n < 64; n++) begin
            if (pos < 0 || line_idx < 0 || line_idx >= MAP_SIDE) return 0;
            other = pos >>> 22;
            if (other >= MAP_SIDE) return 0;
            if (horiz ? is_wall(line_idx, other) : is_wall(other, line_idx)) begin
                prod = dd * (horiz ? csc_q16[ref_deg] : csc_q16[90 - ref_deg]);
                hit_dist = (prod < 0) ? 0
                         : (longint'(prod) > longint'(DIST_SAT)) ? DIST_SAT : prod;
                return 1;
            end
            pos += fwd ? step : -step;
            dd += 64;
            line_idx += dec ? -1 : 1;
        end
        return 0;
    endfunction

    // Predicts the slices of every ray of one frame.
    task automatic predict_frame(logic [9:0] vx, logic [9:0] vy, logic [8:0] hd);
        int              head, ang, ref_deg, off;
        bit              h_hit, v_hit, dark;
        longint unsigned dh, dv, d, len, top, bottom;
        t_slice          s;
        head = hd % 360;
        for (int i = 0; i < RAY_COUNT; i++) begin
            ang = (head + 360 + HALF_RAYS - i) % 360;
            off = (HALF_RAYS - i < 0) ? i - HALF_RAYS : HALF_RAYS - i;
            if (off > 90) off = 90;
            if (ang <= 90) ref_deg = ang;
            else if (ang <= 180) ref_deg = 180 - ang;
            else if (ang <= 270) ref_deg = ang - 180;
            else ref_deg = 360 - ang;
            h_hit = 0;
            v_hit = 0;
            dh = 0;
            dv = 0;
            if (ang != 0 && ang != 180) h_hit = walk_lines(1, vx, vy, ang, ref_deg, dh);
            if (ang != 90 && ang != 270) v_hit = walk_lines(0, vx, vy, ang, ref_deg, dv);
            dark = v_hit && (!h_hit || dv < dh);
            d = dark ? dv : dh;
            if (!h_hit && !v_hit) begin
                top = CENTER_ROW;
                bottom = CENTER_ROW;
                dark = 0;
            end else begin
                d = (d * longint'(sine_q16[90 - off])) >> 16;
                if (d > DIST_SAT) d = DIST_SAT;
                len = (d == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd871786112 / d;
                if (len / 2 > CENTER_ROW) begin
                    top = 0;
                    bottom = SCREEN_ROWS;
                end else begin
                    top = CENTER_ROW - len / 2;
                    bottom = (len > SCREEN_ROWS - top) ? SCREEN_ROWS : top + len;
                end
            end
            s.column = 6'(i);
            s.top = 8'(top);
            s.bottom = 8'(bottom);
            s.dark = dark;
            s.last = (i == RAY_COUNT - 1);
            slice_queue.push_back(s);
        end
    endtask

    // Tracks map writes, predicts on accepted viewer words, checks slice words.
    always @(posedge i_clk) begin
        t_slice want;
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_REG_COUNT; k++) map_bits[k] = '0;
        end else begin
            if (i_cfg_we && i_cfg_index < CFG_REG_COUNT) map_bits[i_cfg_index[1:0]] = i_cfg_data;
            if (i_valid && !i_in_stall) predict_frame(i_viewer_x, i_viewer_y, i_heading_deg);
            if (i_out_valid && !i_out_stall) begin
                if (slice_queue.size() == 0) begin
                    $display("%0t: unexpected slice word column %0d", $time, i_column_index);
                    o_fail_count++;
                end else begin
                    want = slice_queue.pop_front();
                    if (want.column !== i_column_index || want.top !== i_wall_top ||
                        want.bottom !== i_wall_bottom || want.dark !== i_dark_side ||
                        want.last !== i_last_column) begin
                        // Fields are column, top, bottom, dark and last.
                        $display("%0t: slice expected %0d %0d %0d %0d %0d actual %0d %0d %0d %0d %0d",
                                 $time, want.column, want.top, want.bottom, want.dark,
                                 want.last, i_column_index, i_wall_top, i_wall_bottom,
                                 i_dark_side, i_last_column);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = slice_queue.size();
    end

endmodule

### verif/grid_raycast_column_renderer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_raycast_column_renderer_tb: frame stimulus and verdict
// Loads a series of wall maps, sends directed and random viewer words with
// random gaps and output stalls, and reports the checker's result.
// ----------------------------------------------------------------------------
module grid_raycast_column_renderer_tb;
    import rcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [9:0]           i_viewer_x = '0;
    logic [9:0]           i_viewer_y = '0;
    logic [8:0]           i_heading_deg = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [5:0]           o_column_index;
    logic [7:0]           o_wall_top;
    logic [7:0]           o_wall_bottom;
    logic                 o_dark_side;
    logic                 o_last_column;
    int                   fail_count;
    int                   slices_pending;
    bit                   steady_run = 1'b0;
    int                   quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    grid_raycast_column_renderer dut (.*);

    grid_raycast_column_renderer_check u_slice_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_viewer_x(i_viewer_x), .i_viewer_y(i_viewer_y), .i_heading_deg(i_heading_deg),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_column_index(o_column_index),
        .i_wall_top(o_wall_top), .i_wall_bottom(o_wall_bottom), .i_dark_side(o_dark_side),
        .i_last_column(o_last_column), .o_fail_count(fail_count), .o_pending(slices_pending)
    );

    // Random backpressure on the slice channel, off during the steady run.
    always @(negedge i_clk) begin
        i_stall <= steady_run ? 1'b0 : ($urandom_range(99) < 29);
    end

    // Watchdog on cycles with no accepted word on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_map(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
                            logic [63:0] r3);
        write_reg(CFG_MAP_ROWS_0_TO_3, r0);
        write_reg(CFG_MAP_ROWS_4_TO_7, r1);
        write_reg(CFG_MAP_ROWS_8_TO_11, r2);
        write_reg(CFG_MAP_ROWS_12_TO_15, r3);
    endtask

    // Waits until every slice has arrived and the block has gone idle.
    task automatic settle();
        while (slices_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Holds the word until the stall, checked between edges, lets it through.
    task automatic send_view(logic [9:0] vx, logic [9:0] vy, logic [8:0] hd);
        int gap;
        gap = (!steady_run && $urandom_range(99) < 29) ? $urandom_range(12, 1) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_viewer_x <= vx;
        i_viewer_y <= vy;
        i_heading_deg <= hd;
        while (o_stall) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_rows(int density);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (density < 2) v &= {$urandom, $urandom};
        if (density < 1) v &= {$urandom, $urandom};
        return v;
    endfunction

    initial begin
        int dens;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty map: every ray leaves the map, including the parallel ones.
        load_map('0, '0, '0, '0);
        send_view(10'd0, 10'd0, 9'd0);
        send_view(10'd1023, 10'd1023, 9'd511);
        send_view(10'd512, 10'd512, 9'd90);
        send_view(10'd300, 10'd700, 9'd359);
        send_view(10'd5, 10'd9, 9'd360);
        i_valid <= 1'b0;
        settle();

        // Walled border: rays parallel to the grid and diagonals.
        load_map({16'h8001, 16'h8001, 16'h8001, 16'hFFFF}, {4{16'h8001}},
                 {4{16'h8001}}, {16'hFFFF, 16'h8001, 16'h8001, 16'h8001});
        send_view(10'd512, 10'd512, 9'd0);
        send_view(10'd512, 10'd512, 9'd90);
        send_view(10'd512, 10'd512, 9'd180);
        send_view(10'd512, 10'd512, 9'd270);
        send_view(10'd100, 10'd100, 9'd45);
        send_view(10'd960, 10'd960, 9'd225);
        send_view(10'd65, 10'd1000, 9'd135);
        send_view(10'd700, 10'd64, 9'd300);
        i_valid <= 1'b0;
        settle();

        // Solid map: zero distances and slices taller than the screen;
        // writes to unused indexes must be ignored.
        load_map('1, '1, '1, '1);
        write_reg(CFG_IDX_W'(CFG_REG_COUNT), '0);
        write_reg('1, '0);
        send_view(10'd512, 10'd512, 9'd90);
        send_view(10'd512, 10'd512, 9'd0);
        send_view(10'd600, 10'd600, 9'd200);
        send_view(10'd0, 10'd0, 9'd315);
        send_view(10'd1023, 10'd0, 9'd400);
        i_valid <= 1'b0;
        settle();

        // Random maps of varied density with random viewers.
        for (int phase = 0; phase < 5; phase++) begin
            dens = phase % 3;
            load_map(random_rows(dens), random_rows(dens), random_rows(dens),
                     random_rows(dens));
            steady_run = (phase == 2);
            for (int n = 0; n < 22; n++) begin
                send_view(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                          9'($urandom_range(511)));
            end
            i_valid <= 1'b0;
            steady_run = 1'b0;
            settle();
        end

        if (fail_count == 0 && slices_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
